FILE: rtl/core/cpo_pkg.sv
package cpo_pkg;

	localparam int MAX_VERTS_DEF  = 8;
	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W        = 16;
	// Wide enough to zero-extend a field up to the largest coordinate width.
	localparam int EXT_W          = FIELD_W + 24;

	localparam logic POLY_A    = 1'b0;
	localparam logic POLY_B    = 1'b1;
	localparam logic SET_OWN   = 1'b0;
	localparam logic SET_OTHER = 1'b1;

	typedef struct packed {
		logic                      polygon_select;
		logic signed [FIELD_W-1:0] vertex_x;
		logic signed [FIELD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vtx_item_t;

	typedef struct packed {
		logic overlap;
		logic error;
	} res_item_t;

	typedef struct packed {
		logic we;
		logic wr_poly;
		logic rd_poly;
		logic proj_en;
		logic proj_set;
		logic proj_first;
		logic cap_prev;
		logic set_axis;
	} dp_cmd_t;

	typedef struct packed {
		logic separate;
	} dp_status_t;

endpackage

FILE: rtl/core/convex_polygon_overlap_sat.sv
// Loading: one vertex item per cycle while the block is waiting for vertices.
// Test: each edge axis takes reads of the previous and current vertex, axis setup, one vertex projection per cycle
// through the vertex memories, two pipeline stages and a compare.
// In the worst case every edge of both polygons gives an axis; a separating axis ends the test early.
// The result sits in an output register, so loading of the next pair overlaps its wait.
// Reset clears the counts, the overflow flag and the result valid; vertex memories are not cleared.
module convex_polygon_overlap_sat #(
	parameter int MAX_VERTS  = cpo_pkg::MAX_VERTS_DEF,
	parameter int COORD_BITS = cpo_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_ready,
	input  cpo_pkg::vtx_item_t vtx,
	output logic               res_valid,
	input  logic               res_ready,
	output cpo_pkg::res_item_t res
);
	import cpo_pkg::*;

	dp_cmd_t                      cmd;
	dp_status_t                   status;
	logic [$clog2(MAX_VERTS)-1:0] addr;

	cpo_ctrl #(
		.MAX_VERTS(MAX_VERTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cmd       (cmd),
		.addr      (addr),
		.status    (status)
	);

	cpo_dp #(
		.MAX_VERTS (MAX_VERTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.cmd    (cmd),
		.addr   (addr),
		.status (status)
	);

endmodule

FILE: rtl/core/cpo_dp.sv
module cpo_dp #(
	parameter int MAX_VERTS  = cpo_pkg::MAX_VERTS_DEF,
	parameter int COORD_BITS = cpo_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cpo_pkg::vtx_item_t           vtx,
	input  cpo_pkg::dp_cmd_t             cmd,
	input  logic [$clog2(MAX_VERTS)-1:0] addr,
	output cpo_pkg::dp_status_t          status
);
	import cpo_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int EW = CW + 1;
	localparam int DW = 2 * CW + 2;

	logic [EXT_W-1:0] ext_x, ext_y;
	logic [2*CW-1:0]  wdata;

	logic [2*CW-1:0] mem_a [MAX_VERTS];
	logic [2*CW-1:0] mem_b [MAX_VERTS];
	logic [2*CW-1:0] rd_a_s1, rd_b_s1, rd_s1;
	logic            poly_s1, valid_s1, set_s1, first_s1;

	logic signed [CW-1:0] px, py;
	logic signed [EW-1:0] px_e, py_e;
	logic signed [CW-1:0] prev_x_q, prev_y_q;
	logic signed [EW-1:0] ax_q, ay_q;

	logic signed [DW-1:0] prod_x_s2, prod_y_s2, dot;
	logic                 valid_s2, set_s2, first_s2;
	logic signed [DW-1:0] own_min_q, own_max_q, oth_min_q, oth_max_q;

	// Coordinates are taken from the low COORD_BITS of the zero-extended field.
	assign ext_x = {{(EXT_W-FIELD_W){1'b0}}, vtx.vertex_x};
	assign ext_y = {{(EXT_W-FIELD_W){1'b0}}, vtx.vertex_y};
	assign wdata = {ext_x[CW-1:0], ext_y[CW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.we && cmd.wr_poly == POLY_A) begin
			mem_a[addr] <= wdata;
		end
		if (cmd.we && cmd.wr_poly == POLY_B) begin
			mem_b[addr] <= wdata;
		end
		rd_a_s1 <= mem_a[addr];
		rd_b_s1 <= mem_b[addr];
	end

	assign rd_s1 = (poly_s1 == POLY_B) ? rd_b_s1 : rd_a_s1;
	assign px    = $signed(rd_s1[2*CW-1:CW]);
	assign py    = $signed(rd_s1[CW-1:0]);
	assign px_e  = {px[CW-1], px};
	assign py_e  = {py[CW-1], py};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.proj_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		poly_s1  <= cmd.rd_poly;
		set_s1   <= cmd.proj_set;
		first_s1 <= cmd.proj_first;
		set_s2   <= set_s1;
		first_s2 <= first_s1;
		if (cmd.cap_prev) begin
			prev_x_q <= px;
			prev_y_q <= py;
		end
		// The axis is the edge normal (dy, -dx).
		if (cmd.set_axis) begin
			ax_q <= py_e - {prev_y_q[CW-1], prev_y_q};
			ay_q <= {prev_x_q[CW-1], prev_x_q} - px_e;
		end
		prod_x_s2 <= ax_q * px_e;
		prod_y_s2 <= ay_q * py_e;
	end

	assign dot = prod_x_s2 + prod_y_s2;

	always_ff @(posedge clk) begin
		if (valid_s2 && set_s2 == SET_OWN) begin
			if (first_s2 || dot < own_min_q) begin
				own_min_q <= dot;
			end
			if (first_s2 || dot > own_max_q) begin
				own_max_q <= dot;
			end
		end
		if (valid_s2 && set_s2 == SET_OTHER) begin
			if (first_s2 || dot < oth_min_q) begin
				oth_min_q <= dot;
			end
			if (first_s2 || dot > oth_max_q) begin
				oth_max_q <= dot;
			end
		end
	end

	assign status.separate = (own_max_q < oth_min_q) || (oth_max_q < own_min_q);

endmodule

FILE: rtl/core/cpo_ctrl.sv
module cpo_ctrl #(
	parameter int MAX_VERTS = cpo_pkg::MAX_VERTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vtx_valid,
	output logic                         vtx_ready,
	input  cpo_pkg::vtx_item_t           vtx,
	output logic                         res_valid,
	input  logic                         res_ready,
	output cpo_pkg::res_item_t           res,
	output cpo_pkg::dp_cmd_t             cmd,
	output logic [$clog2(MAX_VERTS)-1:0] addr,
	input  cpo_pkg::dp_status_t          status
);
	import cpo_pkg::*;

	localparam int AW   = $clog2(MAX_VERTS);
	localparam int CNTW = $clog2(MAX_VERTS + 1);

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_EDGE0  = 4'd2;
	localparam logic [3:0] S_EDGE1  = 4'd3;
	localparam logic [3:0] S_AXIS   = 4'd4;
	localparam logic [3:0] S_PROJ   = 4'd5;
	localparam logic [3:0] S_DRAIN1 = 4'd6;
	localparam logic [3:0] S_DRAIN2 = 4'd7;
	localparam logic [3:0] S_CMP    = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]      state_q;
	logic [CNTW-1:0] count_a_q, count_b_q;
	logic            ovf_q;
	logic            phase_q, set_q;
	logic [AW-1:0]   t_q, prev_q, idx_q;
	logic            pend_ovl_q, pend_err_q;
	logic            res_valid_q;
	res_item_t       res_q;

	logic            accept, room_a, room_b, slot_free;
	logic [CNTW-1:0] own_cnt, oth_cnt, own_m1, oth_m1, a_m1, b_m1;
	logic [AW-1:0]   own_last, oth_last, cur_last;

	assign accept    = vtx_valid && vtx_ready;
	assign room_a    = count_a_q < CNTW'(MAX_VERTS);
	assign room_b    = count_b_q < CNTW'(MAX_VERTS);
	assign slot_free = !res_valid_q || res_ready;

	// The polygon whose edges give the axes is "own"; the other one is projected too.
	assign own_cnt  = (phase_q == POLY_A) ? count_a_q : count_b_q;
	assign oth_cnt  = (phase_q == POLY_A) ? count_b_q : count_a_q;
	assign own_m1   = own_cnt - CNTW'(1);
	assign oth_m1   = oth_cnt - CNTW'(1);
	assign a_m1     = count_a_q - CNTW'(1);
	assign b_m1     = count_b_q - CNTW'(1);
	assign own_last = own_m1[AW-1:0];
	assign oth_last = oth_m1[AW-1:0];
	assign cur_last = (set_q == SET_OWN) ? own_last : oth_last;

	assign vtx_ready = (state_q == S_LOAD);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		cmd  = '0;
		addr = '0;
		case (state_q)
			S_LOAD: begin
				cmd.wr_poly = vtx.polygon_select;
				if (vtx.polygon_select == POLY_B) begin
					addr   = count_b_q[AW-1:0];
					cmd.we = accept && room_b;
				end else begin
					addr   = count_a_q[AW-1:0];
					cmd.we = accept && room_a;
				end
			end
			S_EDGE0: begin
				cmd.rd_poly = phase_q;
				addr        = prev_q;
			end
			S_EDGE1: begin
				cmd.rd_poly  = phase_q;
				cmd.cap_prev = 1'b1;
				addr         = t_q;
			end
			S_AXIS: begin
				cmd.set_axis = 1'b1;
			end
			S_PROJ: begin
				cmd.rd_poly    = phase_q ^ set_q;
				cmd.proj_en    = 1'b1;
				cmd.proj_set   = set_q;
				cmd.proj_first = (idx_q == '0);
				addr           = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q     <= POLY_A;
			set_q       <= SET_OWN;
			t_q         <= '0;
			prev_q      <= '0;
			idx_q       <= '0;
			pend_ovl_q  <= 1'b0;
			pend_err_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !(state_q == S_DONE && slot_free)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (vtx.polygon_select == POLY_B) begin
							if (room_b) begin
								count_b_q <= count_b_q + CNTW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
							if (vtx.last_vertex) begin
								state_q <= S_CHECK;
							end
						end else begin
							if (room_a) begin
								count_a_q <= count_a_q + CNTW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				S_CHECK: begin
					if (ovf_q || count_a_q == '0 || count_b_q == '0) begin
						pend_err_q <= 1'b1;
						pend_ovl_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						pend_err_q <= 1'b0;
						phase_q    <= POLY_A;
						t_q        <= '0;
						prev_q     <= a_m1[AW-1:0];
						state_q    <= S_EDGE0;
					end
				end
				S_EDGE0: begin
					state_q <= S_EDGE1;
				end
				S_EDGE1: begin
					state_q <= S_AXIS;
				end
				S_AXIS: begin
					idx_q   <= '0;
					set_q   <= SET_OWN;
					state_q <= S_PROJ;
				end
				S_PROJ: begin
					if (idx_q == cur_last) begin
						if (set_q == SET_OWN) begin
							set_q <= SET_OTHER;
							idx_q <= '0;
						end else begin
							state_q <= S_DRAIN1;
						end
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_DRAIN1: begin
					state_q <= S_DRAIN2;
				end
				S_DRAIN2: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (status.separate) begin
						pend_ovl_q <= 1'b0;
						state_q    <= S_DONE;
					end else if (t_q == own_last) begin
						if (phase_q == POLY_A) begin
							phase_q <= POLY_B;
							t_q     <= '0;
							prev_q  <= b_m1[AW-1:0];
							state_q <= S_EDGE0;
						end else begin
							pend_ovl_q <= 1'b1;
							state_q    <= S_DONE;
						end
					end else begin
						prev_q  <= t_q;
						t_q     <= t_q + AW'(1);
						state_q <= S_EDGE0;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						count_a_q   <= '0;
						count_b_q   <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			res_q.overlap <= pend_ovl_q;
			res_q.error   <= pend_err_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_a_q <= CNTW'(MAX_VERTS) && count_b_q <= CNTW'(MAX_VERTS))
		else $error("vertex count exceeds capacity");

	a_err_no_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.error && res_q.overlap))
		else $error("result flags both overlap and error");

	a_last_b_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && vtx.polygon_select == POLY_B && vtx.last_vertex) |=> state_q == S_CHECK)
		else $error("last vertex of B did not start the test");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && slot_free)
		|=> (res_valid_q && count_a_q == '0 && count_b_q == '0 && !ovf_q))
		else $error("result issue did not clear the counts");

endmodule

FILE: dv/cpo_sat_checker.sv
module cpo_sat_checker #(
	parameter int MAX_VERTS  = cpo_pkg::MAX_VERTS_DEF,
	parameter int COORD_BITS = cpo_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	input  logic               vtx_ready,
	input  cpo_pkg::vtx_item_t vtx,
	input  logic               res_valid,
	input  logic               res_ready,
	input  cpo_pkg::res_item_t res,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import cpo_pkg::*;

	// Index 0 holds polygon A, index 1 polygon B.
	longint    vert_x [2][MAX_VERTS];
	longint    vert_y [2][MAX_VERTS];
	int        vert_cnt [2];
	bit        overflow_seen;
	res_item_t expected_results [$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		checked       = 0;
		vert_cnt[0]   = 0;
		vert_cnt[1]   = 0;
		overflow_seen = 0;
	end

	function automatic longint coord_val(logic [FIELD_W-1:0] raw);
		longint u;
		longint mask;
		mask = (longint'(1) << COORD_BITS) - 1;
		u = longint'({1'b0, raw}) & mask;
		if (u[COORD_BITS-1])
			u = u - (longint'(1) << COORD_BITS);
		return u;
	endfunction

	// True if some edge normal of polygon e splits the projections of e and o.
	function automatic bit edges_split(int e, int o);
		longint ax, ay, d;
		longint e_lo, e_hi, o_lo, o_hi;
		int prev;
		prev = vert_cnt[e] - 1;
		for (int t = 0; t < vert_cnt[e]; t++) begin
			ax = vert_y[e][t] - vert_y[e][prev];
			ay = vert_x[e][prev] - vert_x[e][t];
			for (int i = 0; i < vert_cnt[e]; i++) begin
				d = ax * vert_x[e][i] + ay * vert_y[e][i];
				if (i == 0 || d < e_lo) e_lo = d;
				if (i == 0 || d > e_hi) e_hi = d;
			end
			for (int i = 0; i < vert_cnt[o]; i++) begin
				d = ax * vert_x[o][i] + ay * vert_y[o][i];
				if (i == 0 || d < o_lo) o_lo = d;
				if (i == 0 || d > o_hi) o_hi = d;
			end
			if (e_hi < o_lo || o_hi < e_lo)
				return 1'b1;
			prev = t;
		end
		return 1'b0;
	endfunction

	function automatic void take_vertex(vtx_item_t v);
		int p;
		res_item_t r;
		p = (v.polygon_select == POLY_B) ? 1 : 0;
		if (vert_cnt[p] < MAX_VERTS) begin
			vert_x[p][vert_cnt[p]] = coord_val(v.vertex_x);
			vert_y[p][vert_cnt[p]] = coord_val(v.vertex_y);
			vert_cnt[p]++;
		end else begin
			overflow_seen = 1'b1;
		end
		if (p == 1 && v.last_vertex) begin
			r.error   = overflow_seen || vert_cnt[0] == 0 || vert_cnt[1] == 0;
			r.overlap = !r.error && !edges_split(0, 1) && !edges_split(1, 0);
			expected_results = {expected_results, r};
			vert_cnt[0]   = 0;
			vert_cnt[1]   = 0;
			overflow_seen = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got overlap=%0b error=%0b",
						$time, res.overlap, res.error);
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (res.overlap !== want.overlap) begin
						fail_count++;
						$display("%0t: overlap mismatch, expected %0b, got %0b",
							$time, want.overlap, res.overlap);
					end
					if (res.error !== want.error) begin
						fail_count++;
						$display("%0t: error flag mismatch, expected %0b, got %0b",
							$time, want.error, res.error);
					end
				end
			end
			if (vtx_valid && vtx_ready)
				take_vertex(vtx);
			pending = expected_results.size();
		end
	end

endmodule

FILE: dv/tb_convex_polygon_overlap_sat.sv
module tb_convex_polygon_overlap_sat;
	timeunit 1ns;
	timeprecision 1ps;

	import cpo_pkg::*;

	localparam int MAX_VERTS       = MAX_VERTS_DEF;
	localparam int COORD_BITS      = COORD_BITS_DEF;
	localparam int C_MAX           = 2 ** (FIELD_W - 1) - 1;
	localparam int C_MIN           = -(2 ** (FIELD_W - 1));
	localparam int RANDOM_ITEMS    = 1200;
	localparam int IDLE_LIMIT      = 20000;
	localparam int PRESSURE_AT     = 40;
	localparam int PRESSURE_CYCLES = 1500;
	localparam int DRAIN_CYCLES    = 400;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      vtx_valid = 1'b0;
	logic      res_ready = 1'b0;
	vtx_item_t vtx       = '0;
	logic      vtx_ready;
	logic      res_valid;
	res_item_t res;

	int fail_count;
	int pending;
	int checked;
	int items_sent = 0;
	bit sender_quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	convex_polygon_overlap_sat #(
		.MAX_VERTS (MAX_VERTS),
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx_valid(vtx_valid),
		.vtx_ready(vtx_ready),
		.vtx      (vtx),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	cpo_sat_checker #(
		.MAX_VERTS (MAX_VERTS),
		.COORD_BITS(COORD_BITS)
	) sat_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	// Mostly no gap or a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [FIELD_W-1:0] clip(int v);
		if (v > C_MAX) v = C_MAX;
		else if (v < C_MIN) v = C_MIN;
		return v[FIELD_W-1:0];
	endfunction

	function automatic int offset(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly ordinary sizes, some tiny ones and a few that overflow the store.
	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return MAX_VERTS + $urandom_range(1, 2);
		if (r < 15) return $urandom_range(1, 2);
		return $urandom_range(3, MAX_VERTS);
	endfunction

	task automatic send_vertex(logic sel, int x, int y, logic last);
		int gap;
		gap = sender_quiet ? 0 : gap_len();
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx <= vtx_item_t'{polygon_select: sel, vertex_x: clip(x), vertex_y: clip(y),
			last_vertex: last};
		vtx_valid <= 1'b1;
		@(posedge clk);
		while (!vtx_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_cluster(logic sel, int n, int cx, int cy, int span, bit mark);
		for (int i = 0; i < n; i++)
			send_vertex(sel, cx + offset(span), cy + offset(span), mark && i == n - 1);
	endtask

	// Corners in counterclockwise order, so the polygon is convex.
	task automatic send_box(logic sel, int x0, int y0, int w, int h, bit mark);
		send_vertex(sel, x0, y0, 1'b0);
		send_vertex(sel, x0 + w, y0, 1'b0);
		send_vertex(sel, x0 + w, y0 + h, 1'b0);
		send_vertex(sel, x0, y0 + h, mark);
	endtask

	task automatic send_wide(logic sel, int n, bit mark);
		for (int i = 0; i < n; i++)
			send_vertex(sel, $signed(16'($urandom)), $signed(16'($urandom)),
				mark && i == n - 1);
	endtask

	initial begin
		int kind, cx, cy, span, x0, y0, w, h, dx;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Polygon A empty when B ends.
		send_vertex(POLY_B, 0, 0, 1'b1);
		// Two squares sharing an edge: touching counts as overlap.
		send_box(POLY_A, 0, 0, 16, 16, 1'b1);
		send_box(POLY_B, 16, 0, 16, 16, 1'b1);
		// Coordinate extremes, A vertices after A's mark, and a repeated vertex.
		send_vertex(POLY_A, C_MIN, C_MIN, 1'b1);
		send_vertex(POLY_A, C_MIN, C_MIN, 1'b0);
		send_vertex(POLY_A, C_MAX, C_MIN, 1'b0);
		send_vertex(POLY_A, C_MAX, C_MAX, 1'b0);
		send_vertex(POLY_B, C_MIN, C_MAX, 1'b1);
		// One vertex more than A can hold.
		for (int i = 0; i <= MAX_VERTS; i++)
			send_vertex(POLY_A, i * 16, (i % 3) * 16, i == MAX_VERTS);
		send_vertex(POLY_B, 0, 0, 1'b1);

		while (items_sent < 24 + RANDOM_ITEMS) begin
			sender_quiet = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				cx   = offset(2000);
				cy   = offset(2000);
				span = $urandom_range(16, 1500);
				send_cluster(POLY_A, pick_count(), cx, cy, span, $urandom_range(0, 4) != 0);
				send_cluster(POLY_B, pick_count(), cx + offset(2 * span), cy + offset(2 * span),
					$urandom_range(16, 1500), 1'b1);
			end else if (kind < 60) begin
				x0 = offset(20000);
				y0 = offset(20000);
				w  = $urandom_range(1, 4000);
				h  = $urandom_range(1, 4000);
				case ($urandom_range(0, 3))
					0: dx = -1;
					1: dx = 0;
					2: dx = 1;
					default: dx = offset(w);
				endcase
				send_box(POLY_A, x0, y0, w, h, 1'($urandom_range(0, 1)));
				send_box(POLY_B, x0 + w + dx, y0 + offset(h), $urandom_range(1, 4000),
					$urandom_range(1, 4000), 1'b1);
			end else if (kind < 80) begin
				send_wide(POLY_A, pick_count(), 1'($urandom_range(0, 1)));
				send_wide(POLY_B, pick_count(), 1'b1);
			end else begin
				// Loose items: random polygon, random marks, broken pairs.
				repeat ($urandom_range(1, 12))
					send_vertex(1'($urandom_range(0, 1)), $signed(16'($urandom)),
						$signed(16'($urandom)), $urandom_range(0, 9) < 3);
			end
		end

		vtx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Drove %0d vertex items through directed and random polygon pairs,",
			items_sent);
		$display("and compared %0d overlap and error results with the prediction.", checked);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls, quiet stretches, and one long hold-off that
	// lets the block fill up and push back on the vertex side.
	initial begin
		int n_res, stall;
		bit quiet, pressured;
		n_res     = 0;
		stall     = 0;
		quiet     = 1'b0;
		pressured = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) n_res++;
			if ($urandom_range(0, 199) == 0) quiet = !quiet;
			if (!arst_n) begin
				res_ready <= 1'b0;
			end else if (!pressured && n_res >= PRESSURE_AT) begin
				pressured = 1'b1;
				res_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				res_ready <= 1'b0;
				stall--;
			end else begin
				res_ready <= 1'b1;
				if (!quiet) stall = gap_len();
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((vtx_valid && vtx_ready) || (res_valid && res_ready)) idle = 0;
			else idle++;
		end
		$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

endmodule
